// ----- rtl/rog_pkg.sv -----
// Package for range_outlier_gate: beat types, register indexes, FSM states
// and fixed-point constants. No dependencies.
package rog_pkg;

  localparam int Q_SHIFT = 24;

  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;
  localparam logic [15:0] MIN_DISTANCE_RESET = 16'd10;
  localparam logic [31:0] SPEED_MAX          = 32'h7FFF_FFFF;
  localparam logic [31:0] SPEED_MIN          = 32'h8000_0000;

  localparam logic [0:0] ACT_SAMPLE = 1'b0;
  localparam logic [0:0] ACT_START  = 1'b1;

  localparam logic [1:0] REG_INIT_POSITION = 2'd0;
  localparam logic [1:0] REG_INIT_SPEED    = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED     = 2'd2;
  localparam logic [1:0] REG_MIN_DISTANCE  = 2'd3;

  typedef struct packed {
    logic [0:0]  action;
    logic [31:0] timestamp_us;
    logic [15:0] distance;
  } rog_sample_t;

  typedef struct packed {
    logic [15:0] filtered_distance;
    logic [0:0]  is_outlier;
    logic [15:0] outlier_total;
  } rog_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEV,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } rog_state_t;

endpackage

// ----- rtl/range_outlier_gate.sv -----
// Top level of the range-sample outlier gate. Uses rog_pkg, rog_mul and
// rog_div.
//
// The gate takes one beat at a time. A start beat goes straight to the
// result state. A distance sample runs a 32-step bit-serial multiply (drift
// and allowed deviation in parallel, one elapsed-time bit per cycle), then
// a deviation state and a compare state: a rejected sample, or one with
// zero elapsed time, then goes to the result state. An accepted sample first
// runs the 40-step restoring divider for the new speed. A new beat is taken
// as soon as the previous result sits in the output register, even while
// that result waits for result_ready.
module range_outlier_gate
  import rog_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  rog_sample_t sample,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output rog_result_t result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0] initial_position;
  logic [31:0] initial_speed;
  logic [30:0] max_speed;
  logic [15:0] min_distance;

  // Tracker state.
  logic [15:0] last_position;
  logic [31:0] last_speed;
  logic [31:0] last_time;
  logic [15:0] rejected_count;

  // Per-sample working registers.
  logic [15:0] dist_r;
  logic [31:0] ts_r;
  logic [31:0] dt_r;
  logic [15:0] gap_abs_r;
  logic        gap_neg_r;
  logic        spd_neg_r;
  logic        below_min_r;
  logic        num_neg_r;
  logic [63:0] dev_r;
  logic        outlier_r;

  rog_state_t state, state_next;

  logic        sample_take;
  logic        mul_start;
  logic        div_start;
  logic        out_load;
  logic        reject;

  logic [31:0] dt_now;
  logic [31:0] spd_mag;
  logic        mul_done;
  logic [63:0] drift;
  logic [62:0] allowed;
  logic        div_done;
  logic [39:0] quo_mag;
  logic [31:0] speed_sat;
  logic [63:0] gap_wide;
  logic        cfg_wr;

  // APB: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_INIT_POSITION: prdata = {16'd0, initial_position};
      REG_INIT_SPEED:    prdata = initial_speed;
      REG_MAX_SPEED:     prdata = {1'b0, max_speed};
      REG_MIN_DISTANCE:  prdata = {16'd0, min_distance};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_position <= '0;
      initial_speed    <= '0;
      max_speed        <= '0;
      min_distance     <= MIN_DISTANCE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_INIT_POSITION: initial_position <= pwdata[15:0];
        REG_INIT_SPEED:    initial_speed    <= pwdata;
        REG_MAX_SPEED:     max_speed        <= pwdata[30:0];
        REG_MIN_DISTANCE:  min_distance     <= pwdata[15:0];
        default:           ;
      endcase
    end
  end

  // Elapsed time wraps with the microsecond counter.
  assign dt_now  = sample.timestamp_us - last_time;
  assign spd_mag = last_speed[31] ? (~last_speed + 32'd1) : last_speed;

  rog_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .start      (mul_start),
    .multiplier (dt_now),
    .mcand_a    (spd_mag),
    .mcand_b    (max_speed),
    .done       (mul_done),
    .prod_a     (drift),
    .prod_b     (allowed)
  );

  rog_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({gap_abs_r, 24'd0}),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo_mag)
  );

  // Position gap scaled to Q.24 for the deviation sum.
  assign gap_wide = {24'd0, gap_abs_r, 24'd0};
  assign reject   = below_min_r || (dev_r > {1'b0, allowed});

  // Truncated quotient magnitude, signed and clamped to 32 bits.
  always_comb begin
    if (num_neg_r) begin
      if (quo_mag > {8'd0, SPEED_MIN}) begin
        speed_sat = SPEED_MIN;
      end else begin
        speed_sat = ~quo_mag[31:0] + 32'd1;
      end
    end else begin
      if (quo_mag > {8'd0, SPEED_MAX}) begin
        speed_sat = SPEED_MAX;
      end else begin
        speed_sat = quo_mag[31:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = (sample.action == ACT_START) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV: state_next = ST_CMP;
      ST_CMP: begin
        state_next = (reject || dt_r == 32'd0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    sample_ready = (state == ST_IDLE);
    sample_take  = sample_ready && sample_valid;
    mul_start    = sample_take && (sample.action == ACT_SAMPLE);
    div_start    = (state == ST_CMP) && !reject && (dt_r != 32'd0);
    out_load     = (state == ST_FIN) && (!result_valid || result_ready);
  end

  // Control and tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      last_position  <= '0;
      last_speed     <= '0;
      last_time      <= '0;
      rejected_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (sample_take && sample.action == ACT_START) begin
        // Reload from configuration and restart the reject count.
        last_position  <= initial_position;
        last_speed     <= initial_speed;
        last_time      <= sample.timestamp_us;
        rejected_count <= '0;
      end else if (state == ST_CMP) begin
        if (reject) begin
          if (rejected_count != COUNT_MAX) begin
            rejected_count <= rejected_count + 16'd1;
          end
        end else if (dt_r == 32'd0) begin
          // No elapsed time: keep the sample, drop the speed to zero.
          last_speed    <= '0;
          last_position <= dist_r;
          last_time     <= ts_r;
        end
      end else if (state == ST_DIV && div_done) begin
        last_speed    <= speed_sat;
        last_position <= dist_r;
        last_time     <= ts_r;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (sample_take) begin
      dist_r      <= sample.distance;
      ts_r        <= sample.timestamp_us;
      dt_r        <= dt_now;
      spd_neg_r   <= last_speed[31];
      gap_neg_r   <= last_position < sample.distance;
      num_neg_r   <= last_position > sample.distance;
      gap_abs_r   <= (last_position < sample.distance) ?
                     (sample.distance - last_position) :
                     (last_position - sample.distance);
      below_min_r <= sample.distance < min_distance;
      outlier_r   <= 1'b0;
    end
    if (state == ST_DEV) begin
      // Same sign: magnitudes add; opposite signs: take the difference.
      if (spd_neg_r == gap_neg_r) begin
        dev_r <= drift + gap_wide;
      end else if (drift > gap_wide) begin
        dev_r <= drift - gap_wide;
      end else begin
        dev_r <= gap_wide - drift;
      end
    end
    if (state == ST_CMP) begin
      outlier_r <= reject;
    end
    if (out_load) begin
      result.filtered_distance <= last_position;
      result.is_outlier        <= outlier_r;
      result.outlier_total     <= rejected_count;
    end
  end

endmodule

// ----- rtl/rog_mul.sv -----
// Bit-serial shift-add multiplier: two products that share one 32-bit
// multiplier, one multiplier bit per cycle. No dependencies.
module rog_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] multiplier,
  input  logic [31:0] mcand_a,
  input  logic [30:0] mcand_b,
  output logic        done,
  output logic [63:0] prod_a,
  output logic [62:0] prod_b
);

  localparam int STEPS = 32;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] count;
  logic [31:0]   mult;
  logic [31:0]   ca;
  logic [30:0]   cb;
  logic [31:0]   hi_a;
  logic [31:0]   lo_a;
  logic [30:0]   hi_b;
  logic [31:0]   lo_b;
  logic [32:0]   sum_a;
  logic [31:0]   sum_b;

  assign sum_a = {1'b0, hi_a} + (mult[0] ? {1'b0, ca} : 33'd0);
  assign sum_b = {1'b0, hi_b} + (mult[0] ? {1'b0, cb} : 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right, add the multiplicand on a one bit.
  always_ff @(posedge clk) begin
    if (start) begin
      mult <= multiplier;
      ca   <= mcand_a;
      cb   <= mcand_b;
      hi_a <= '0;
      lo_a <= '0;
      hi_b <= '0;
      lo_b <= '0;
    end else if (busy) begin
      hi_a <= sum_a[32:1];
      lo_a <= {sum_a[0], lo_a[31:1]};
      hi_b <= sum_b[31:1];
      lo_b <= {sum_b[0], lo_b[31:1]};
      mult <= {1'b0, mult[31:1]};
    end
  end

  assign prod_a = {hi_a, lo_a};
  assign prod_b = {hi_b, lo_b};

endmodule

// ----- rtl/rog_div.sv -----
// Restoring divider for unsigned magnitudes, one quotient bit per cycle:
// 40-bit dividend by 32-bit divisor. No dependencies.
module rog_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);

  localparam int STEPS = 40;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] count;
  logic [31:0]   dsr;
  logic [31:0]   rem;
  logic [39:0]   quo;
  logic [32:0]   rem_shift;
  logic [33:0]   diff;

  assign rem_shift = {rem, quo[39]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in the next dividend bit; keep the difference when no borrow.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff[31:0];
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= rem_shift[31:0];
        quo <= {quo[38:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for range_outlier_gate: directed table, back-to-back reject
// burst and random phases, with a shadow predictor of the prediction gate.
// Depends on rog_pkg and the range_outlier_gate RTL only.
`timescale 1ns / 100ps

module tb_top;
  import rog_pkg::*;

  // Row marker: leave the register settings as they are.
  localparam int KEEP_SETTINGS = -1;

  typedef struct {
    logic [15:0] pos;
    logic [31:0] spd;
    logic [30:0] maxs;
    logic [15:0] mind;
  } setting_t;

  typedef struct {
    int          cfg_sel;
    rog_sample_t beat;
    bit          typed;
    rog_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  rog_sample_t sample       = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  rog_result_t result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  range_outlier_gate dut (.*);

  // Register shadows, as the block should hold them.
  logic [15:0] cfg_init_pos   = '0;
  logic [31:0] cfg_init_speed = '0;
  logic [30:0] cfg_max_speed  = '0;
  logic [15:0] cfg_min_dist   = MIN_DISTANCE_RESET;

  // Tracker state of the predictor.
  logic [15:0] trk_pos    = '0;
  logic [31:0] trk_speed  = '0;
  logic [31:0] trk_time   = '0;
  logic [15:0] reject_cnt = '0;

  rog_result_t gated_results_q[$];
  rog_result_t due_result;
  int          err_cnt = 0;
  int          gap_pct = 25;

  // Settings used by the directed rows, selected by cfg_sel.
  setting_t dir_cfg [4] = '{
    '{16'hFFFF, 32'h0000_0000, 31'h7FFF_FFFF, 16'd0},
    '{16'd1000, 32'h7FFF_FFFF, 31'd1,         16'd0},
    '{16'd2000, 32'h8000_0000, 31'h0100_0000, 16'd0},
    '{16'd0,    32'h0000_0000, 31'h7FFF_FFFF, 16'hFFFF}
  };

  // Directed beats. Typed expectations only where they are obvious; the rest
  // go through the predictor.
  plan_row_t plan [23] = '{
    // reset settings: min distance 10, max speed 0
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd0, 16'd0},           1'b1, {16'd0, 1'b1, 16'd1}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd0, 16'd9},           1'b1, {16'd0, 1'b1, 16'd2}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd0, 16'd10},          1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'hFFFF_FFFF, 16'd10},  1'b0, '0},
    '{KEEP_SETTINGS, {ACT_START, 32'h1234_5678, 16'hFFFF}, 1'b1, {16'd0, 1'b0, 16'd0}},
    // top position, widest gate, zero elapsed time, wrapping time
    '{0, {ACT_START, 32'd1000, 16'd0},                     1'b1, {16'hFFFF, 1'b0, 16'd0}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd1000, 16'hFFFF},     1'b1, {16'hFFFF, 1'b0, 16'd0}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd1001, 16'd0},        1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd999, 16'd0},         1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd0, 16'd0},           1'b0, '0},
    // top speed: speed quotient saturates high, one unit past the gate rejects
    '{1, {ACT_START, 32'hFFFF_FFFF, 16'd0},                1'b1, {16'd1000, 1'b0, 16'd0}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd0, 16'd1128},        1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd1, 16'd1257},        1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd1, 16'd1256},        1'b0, '0},
    // bottom speed: saturates low, then hits the low end exactly
    '{2, {ACT_START, 32'd500, 16'd0},                      1'b1, {16'd2000, 1'b0, 16'd0}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd501, 16'd1871},      1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd502, 16'd1743},      1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd502, 16'd1743},      1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd502, 16'd1744},      1'b0, '0},
    // top minimum distance
    '{3, {ACT_START, 32'd7, 16'd0},                        1'b1, {16'd0, 1'b0, 16'd0}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd8, 16'hFFFE},        1'b1, {16'd0, 1'b1, 16'd1}},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'd9, 16'hFFFF},        1'b0, '0},
    '{KEEP_SETTINGS, {ACT_SAMPLE, 32'h8000_0000, 16'hFFFF}, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run: well above the slowest legal run.
  initial begin
    #150_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Advance the tracker by one beat and return the result it should produce.
  function automatic rog_result_t track_gate(input rog_sample_t b);
    logic [31:0] dt;
    logic [31:0] spd_mag;
    logic [15:0] gap16;
    logic [63:0] drift, gap_mag, dev, allowed;
    logic        spd_neg, gap_neg, reject;
    longint      num, den, quo, hi;
    rog_result_t r;
    r.is_outlier = 1'b0;
    if (b.action == ACT_START) begin
      trk_pos    = cfg_init_pos;
      trk_speed  = cfg_init_speed;
      trk_time   = b.timestamp_us;
      reject_cnt = '0;
    end else begin
      dt      = b.timestamp_us - trk_time;
      spd_neg = trk_speed[31];
      spd_mag = spd_neg ? -trk_speed : trk_speed;
      drift   = 64'(spd_mag) * 64'(dt);
      gap_neg = b.distance > trk_pos;
      gap16   = gap_neg ? b.distance - trk_pos : trk_pos - b.distance;
      gap_mag = 64'(gap16) << Q_SHIFT;
      // Deviation of the sample from the predicted position, in Q.24.
      if (drift == 0 || gap_mag == 0 || spd_neg == gap_neg)
        dev = drift + gap_mag;
      else
        dev = (drift > gap_mag) ? drift - gap_mag : gap_mag - drift;
      allowed = 64'(cfg_max_speed) * 64'(dt);
      reject  = (b.distance < cfg_min_dist) || (dev > allowed);
      if (reject) begin
        r.is_outlier = 1'b1;
        if (reject_cnt != COUNT_MAX) reject_cnt = reject_cnt + 16'd1;
      end else begin
        if (dt == 0) begin
          trk_speed = '0;
        end else begin
          // Truncate toward zero, then clamp to the signed 32-bit range.
          num = (longint'(b.distance) - longint'(trk_pos)) * (longint'(1) <<< Q_SHIFT);
          den = longint'(dt);
          quo = num / den;
          hi  = longint'(SPEED_MAX);
          if (quo > hi) trk_speed = SPEED_MAX;
          else if (quo < -hi - 1) trk_speed = SPEED_MIN;
          else trk_speed = 32'(quo);
        end
        trk_pos  = b.distance;
        trk_time = b.timestamp_us;
      end
    end
    r.filtered_distance = trk_pos;
    r.outlier_total     = reject_cnt;
    return r;
  endfunction

  // Draw a random beat. Most samples follow the tracked trajectory and sit inside
  // or just outside the allowed deviation; the rest are starts and noise.
  function automatic rog_sample_t pick_beat();
    rog_sample_t b;
    logic [31:0] dt;
    longint      aim, allow, lim, spot;
    int          roll;
    roll           = $urandom_range(0, 99);
    b.action       = ACT_SAMPLE;
    b.timestamp_us = $urandom;
    b.distance     = 16'($urandom);
    if (roll < 5) begin
      b.action = ACT_START;
    end else if (roll >= 15) begin
      case ($urandom_range(0, 9))
        0:       dt = '0;
        1:       dt = $urandom;
        2:       dt = $urandom_range(1, 1 << 20);
        default: dt = $urandom_range(1, 2000);
      endcase
      b.timestamp_us = trk_time + dt;
      aim   = longint'(trk_pos) + ((longint'($signed(trk_speed)) * longint'(dt)) >>> Q_SHIFT);
      allow = (longint'(cfg_max_speed) * longint'(dt)) >>> Q_SHIFT;
      lim   = (allow > 3000) ? 3000 : allow;
      case ($urandom_range(0, 9))
        7:       spot = aim + allow + 1 + longint'($urandom_range(0, 50));
        8:       spot = aim - allow - 1 - longint'($urandom_range(0, 50));
        9:       spot = longint'($urandom_range(0, 65535));
        default: spot = aim - lim + longint'($urandom_range(0, 32'(2 * lim)));
      endcase
      if (spot < 0) spot = 0;
      else if (spot > 65535) spot = 65535;
      b.distance = 16'(spot);
    end
    return b;
  endfunction

  function automatic logic [31:0] reg_image(input logic [1:0] idx);
    case (idx)
      REG_INIT_POSITION: return {16'b0, cfg_init_pos};
      REG_INIT_SPEED:    return cfg_init_speed;
      REG_MAX_SPEED:     return {1'b0, cfg_max_speed};
      REG_MIN_DISTANCE:  return {16'b0, cfg_min_dist};
      default:           return '0;
    endcase
  endfunction

  // One APB transfer: setup cycle, then access cycle. Leave the bus as it is at
  // the completing edge so that a following transfer can start in the same step.
  task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!wr && prdata !== val) begin
      $error("prdata reg %0d: expected %h, got %h", idx, val, prdata);
      err_cnt++;
    end
  endtask

  // Read every register back against its shadow, then release the bus.
  task automatic check_regs();
    for (int i = 0; i <= REG_MIN_DISTANCE; i++) reg_access(1'b0, 2'(i), reg_image(2'(i)));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Only call with the block idle: nothing pending, valid low.
  task automatic load_settings(input setting_t s);
    cfg_init_pos   = s.pos;
    cfg_init_speed = s.spd;
    cfg_max_speed  = s.maxs;
    cfg_min_dist   = s.mind;
    for (int i = 0; i <= REG_MIN_DISTANCE; i++) reg_access(1'b1, 2'(i), reg_image(2'(i)));
    check_regs();
  endtask

  // Present one beat, hold it until accepted, then log its expected result.
  // Valid stays high into the next beat unless a gap is drawn.
  task automatic push_beat(input rog_sample_t b, input bit typed, input rog_result_t want);
    rog_result_t calc;
    sample       <= b;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    calc = track_gate(b);
    gated_results_q.push_back(typed ? want : calc);
    if ($urandom_range(0, 99) < gap_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every pending result to come out.
  task automatic settle();
    sample_valid <= 1'b0;
    while (gated_results_q.size() != 0) @(posedge clk);
  endtask

  // Result side back-pressure, drawn fresh every cycle.
  always @(posedge clk) result_ready <= ($urandom_range(0, 99) >= gap_pct);

  // Check each result beat against the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (gated_results_q.size() == 0) begin
        $error("result beat with nothing pending: %h", result);
        err_cnt++;
      end else begin
        due_result = gated_results_q.pop_front();
        if (result.filtered_distance !== due_result.filtered_distance) begin
          $error("filtered_distance: expected %0d, got %0d",
                 due_result.filtered_distance, result.filtered_distance);
          err_cnt++;
        end
        if (result.is_outlier !== due_result.is_outlier) begin
          $error("is_outlier: expected %0d, got %0d", due_result.is_outlier, result.is_outlier);
          err_cnt++;
        end
        if (result.outlier_total !== due_result.outlier_total) begin
          $error("outlier_total: expected %0d, got %0d",
                 due_result.outlier_total, result.outlier_total);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    setting_t    s;
    rog_sample_t b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Reset values of the registers.
    check_regs();

    // Directed table: reload settings between groups once the block drains.
    foreach (plan[i]) begin
      if (plan[i].cfg_sel != KEEP_SETTINGS) begin
        settle();
        load_settings(dir_cfg[plan[i].cfg_sel]);
      end
      push_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // Reject burst: every sample below the minimum distance, back to back with
    // no idling on either side.
    settle();
    gap_pct = 0;
    s = '{16'($urandom), $urandom, 31'd0, 16'hFFFF};
    load_settings(s);
    b.action       = ACT_START;
    b.timestamp_us = $urandom;
    b.distance     = 16'($urandom);
    push_beat(b, 1'b0, '0);
    repeat (150) begin
      b.action       = ACT_SAMPLE;
      b.timestamp_us = $urandom;
      b.distance     = 16'($urandom_range(0, 65534));
      push_beat(b, 1'b0, '0);
    end
    gap_pct = 25;

    // Random phases, each with fresh settings and an opening start beat.
    for (int p = 0; p < 6; p++) begin
      settle();
      s.pos = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       s.spd = '0;
        1:       s.spd = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        2:       s.spd = $urandom;
        default: s.spd = (p % 2) ? SPEED_MAX : SPEED_MIN;
      endcase
      case ($urandom_range(0, 3))
        0:       s.maxs = '0;
        1:       s.maxs = 31'h7FFF_FFFF;
        default: s.maxs = 31'($urandom_range(1 << 16, 1 << 25));
      endcase
      case ($urandom_range(0, 7))
        0:       s.mind = '0;
        1:       s.mind = 16'hFFFF;
        default: s.mind = 16'($urandom_range(0, 200));
      endcase
      load_settings(s);
      b.action       = ACT_START;
      b.timestamp_us = $urandom;
      b.distance     = 16'($urandom);
      push_beat(b, 1'b0, '0);
      repeat (210) push_beat(pick_beat(), 1'b0, '0);
    end

    // Drain, then hold a little longer to catch stray result beats.
    settle();
    repeat (100) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
